// File: sv/pbpm_pkg.sv
// ----------------------------------------------------------------------------
// pbpm_pkg
// Codes and types shared by the page buffer pool manager.
// ----------------------------------------------------------------------------
package pbpm_pkg;

  typedef enum logic [2:0] {
    OP_LOAD       = 3'd0,
    OP_OBTAIN     = 3'd1,
    OP_RELEASE    = 3'd2,
    OP_MARK_DIRTY = 3'd3,
    OP_QUERY      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_BAD_SLOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_POP_RD,
    S_POP_WR,
    S_RD,
    S_WR,
    S_RESP
  } state_t;

  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'h7FFF;

endpackage

// File: sv/pbpm_ram.sv
// ----------------------------------------------------------------------------
// pbpm_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pbpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/page_buffer_pool_manager.sv
// ----------------------------------------------------------------------------
// page_buffer_pool_manager
// Buffer slot pool: free list, reference counts, dirty marks and an
// offset-to-slot map, run by a small sequencer over two slot RAMs.
// ----------------------------------------------------------------------------
//  channel | signals                                  | role
//  --------+------------------------------------------+----------------------
//  in      | in_valid, in_stall, opcode,              | one request per beat
//          | block_offset, slot_index                 |
//  out     | out_valid, out_stall, status, result_slot| one result per beat
//          | hit, fetch_request, writeback_request,   |
//          | writeback_offset, writeback_slot         |
//
// Load: the offset RAM is scanned for the offset, a hit ending the scan; on a
// miss a free slot is popped unless the pool is full, then the result is
// handed off. The offset RAM read port scans one slot per cycle through a
// single compare. Other opcodes: read, modify, write of the slot word, then
// hand off the result. Bad index or unused opcode: straight to the result.
// One request at a time; in_stall is high from accept until the result beat
// is taken. Per-slot init bits stand in for RAM clear.
// ----------------------------------------------------------------------------
module page_buffer_pool_manager #(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           opcode,
  input  logic [31:0]          block_offset,
  input  logic [7:0]           slot_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pbpm_pkg::status_t    status,
  output logic [7:0]           result_slot,
  output logic                 hit,
  output logic                 fetch_request,
  output logic                 writeback_request,
  output logic [31:0]          writeback_offset,
  output logic [7:0]           writeback_slot
);

  import pbpm_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int HW = $clog2(SLOTS + 1);
  localparam int SW = HW + 1 + COUNT_W;
  localparam logic [HW-1:0] END_CODE = HW'(SLOTS);

  state_t state, state_next;

  logic [2:0]       op_q;
  logic [31:0]      off_q;
  logic [AW-1:0]    idx_q;
  logic [HW-1:0]    scan;
  logic             pend;
  logic [AW-1:0]    prev;
  logic [HW-1:0]    free_head;
  logic [AW-1:0]    rd_slot;
  logic [SLOTS-1:0] mapped;
  logic [SLOTS-1:0] touched;

  // offset RAM
  logic          ofs_we;
  logic [AW-1:0] ofs_waddr;
  logic          ofs_re;
  logic [AW-1:0] ofs_raddr;
  logic [31:0]   ofs_rdata;

  // slot word RAM: {link, dirty, count}
  logic          st_we;
  logic [SW-1:0] st_wdata;
  logic          st_re;
  logic [AW-1:0] st_raddr;
  logic [SW-1:0] st_rdata;

  logic [SW-1:0]      cur_word;
  logic [HW-1:0]      cur_link;
  logic               cur_dirty;
  logic [COUNT_W-1:0] cur_cnt;
  logic [COUNT_W-1:0] cnt_dec;
  logic               rel_keep;
  logic               scan_hit;
  logic               idx_ok;

  pbpm_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_ofs_ram (
    .clk   (clk),
    .we    (ofs_we),
    .waddr (ofs_waddr),
    .wdata (off_q),
    .re    (ofs_re),
    .raddr (ofs_raddr),
    .rdata (ofs_rdata)
  );

  pbpm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (idx_q),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // untouched slot reads as its reset word
  assign cur_word  = touched[rd_slot] ? st_rdata
                                      : {HW'(rd_slot) + HW'(1), 1'b0, COUNT_W'(0)};
  assign cur_link  = cur_word[SW-1 -: HW];
  assign cur_dirty = cur_word[COUNT_W];
  assign cur_cnt   = cur_word[COUNT_W-1:0];
  assign cnt_dec   = cur_cnt - COUNT_W'(1);
  assign rel_keep  = (cnt_dec != '0) && !cnt_dec[COUNT_W-1];
  assign scan_hit  = pend && mapped[prev] && (ofs_rdata == off_q);
  assign idx_ok    = {1'b0, slot_index} < 9'(SLOTS);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_LOAD) begin
            state_next = S_SRCH;
          end else if (opcode > OP_QUERY || !idx_ok) begin
            state_next = S_RESP;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_SRCH: begin
        if (scan_hit) begin
          state_next = S_RESP;
        end else if (!pend && scan == END_CODE) begin
          state_next = (free_head == END_CODE) ? S_RESP : S_POP_RD;
        end
      end
      S_POP_RD: state_next = S_POP_WR;
      S_POP_WR: state_next = S_RESP;
      S_RD:     state_next = S_WR;
      S_WR:     state_next = S_RESP;
      S_RESP: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and RAM controls
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ofs_we    = 1'b0;
    ofs_waddr = rd_slot;
    ofs_re    = 1'b0;
    ofs_raddr = idx_q;
    st_we     = 1'b0;
    st_wdata  = cur_word;
    st_re     = 1'b0;
    st_raddr  = idx_q;
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_SRCH: begin
        ofs_re    = (scan < END_CODE);
        ofs_raddr = scan[AW-1:0];
      end
      S_POP_RD: begin
        st_re    = 1'b1;
        st_raddr = free_head[AW-1:0];
      end
      S_POP_WR: ofs_we = 1'b1;
      S_RD: begin
        st_re  = 1'b1;
        ofs_re = 1'b1;
      end
      S_WR: begin
        case (op_q)
          OP_OBTAIN: begin
            st_we    = 1'b1;
            st_wdata = {cur_link, cur_dirty,
                        (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_W'(1)};
          end
          OP_RELEASE: begin
            st_we = 1'b1;
            if (rel_keep) begin
              st_wdata = {cur_link, cur_dirty, cnt_dec};
            end else if (!mapped[rd_slot]) begin
              st_wdata = {cur_link, 1'b0, COUNT_W'(0)};
            end else begin
              st_wdata = {free_head, 1'b0, COUNT_W'(0)};
            end
          end
          OP_MARK_DIRTY: begin
            st_we    = 1'b1;
            st_wdata = {cur_link, 1'b1, cur_cnt};
          end
          default: st_we = 1'b0;
        endcase
      end
      S_RESP:  out_valid = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      mapped    <= '0;
      touched   <= '0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      if (st_we) begin
        touched[idx_q] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q              <= opcode;
            off_q             <= block_offset;
            idx_q             <= slot_index[AW-1:0];
            scan              <= '0;
            pend              <= 1'b0;
            status            <= (opcode != OP_LOAD && opcode <= OP_QUERY && !idx_ok)
                                 ? STAT_BAD_SLOT : STAT_OK;
            result_slot       <= '0;
            hit               <= 1'b0;
            fetch_request     <= 1'b0;
            writeback_request <= 1'b0;
            writeback_offset  <= '0;
            writeback_slot    <= '0;
          end
        end
        S_SRCH: begin
          if (scan_hit) begin
            result_slot <= 8'(prev);
            hit         <= 1'b1;
          end else if (!pend && scan == END_CODE && free_head == END_CODE) begin
            status <= STAT_NO_FREE;
          end
          pend <= (scan < END_CODE);
          prev <= scan[AW-1:0];
          if (scan < END_CODE) begin
            scan <= scan + HW'(1);
          end
        end
        S_POP_RD: rd_slot <= free_head[AW-1:0];
        S_POP_WR: begin
          free_head        <= cur_link;
          mapped[rd_slot]  <= 1'b1;
          result_slot      <= 8'(rd_slot);
          fetch_request    <= 1'b1;
        end
        S_RD: rd_slot <= idx_q;
        S_WR: begin
          case (op_q)
            OP_OBTAIN: result_slot <= 8'(rd_slot);
            OP_RELEASE: begin
              if (!rel_keep && mapped[rd_slot]) begin
                if (cur_dirty) begin
                  writeback_request <= 1'b1;
                  writeback_offset  <= ofs_rdata;
                  writeback_slot    <= 8'(rd_slot);
                end
                mapped[rd_slot] <= 1'b0;
                free_head       <= HW'(rd_slot);
              end
            end
            OP_QUERY: writeback_offset <= mapped[rd_slot] ? ofs_rdata : 32'd0;
            default: ;
          endcase
        end
        S_RESP: ;
        default: ;
      endcase
    end
  end

  // no new request while a result beat waits
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request taken while result pending");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= END_CODE) else $error("free list head out of range");

  a_pop_unmapped: assert property (@(posedge clk) disable iff (rst)
    state == S_POP_WR |-> !mapped[rd_slot]) else $error("popped a mapped slot");

  a_hit_no_fetch: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !fetch_request && status == STAT_OK)
    else $error("hit with fetch or error");

  a_wb_on_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && writeback_request |-> op_q == OP_RELEASE)
    else $error("writeback outside release");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for page_buffer_pool_manager. A shadow copy of the
// slot pool (free list, counts, dirty marks, offset map) predicts each result
// at request accept; results are checked in order, field by field. Directed
// tests cover reset state, each opcode, bad indices, spare opcodes, pool
// exhaustion and a count that climbs and drops back past zero; a long random
// mix follows, with random idling on both channels and one stretch of
// full-rate traffic.
// ----------------------------------------------------------------------------
module testbench;
  import pbpm_pkg::*;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 40;
  localparam int RANDOM_ITEMS = 2000;
  localparam int OFFSET_POOL_N = 24;
  localparam logic [2:0] OP_FIRST_SPARE = 3'd5;
  localparam logic [2:0] OP_LAST_SPARE = 3'd7;

  typedef struct packed {
    status_t     status;
    logic [7:0]  slot;
    logic        hit;
    logic        fetch;
    logic        wb_req;
    logic [31:0] wb_off;
    logic [7:0]  wb_slot;
  } pool_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  opcode;
  logic [31:0] block_offset;
  logic [7:0]  slot_index;
  logic        out_valid;
  logic        out_stall;
  status_t     status;
  logic [7:0]  result_slot;
  logic        hit;
  logic        fetch_request;
  logic        writeback_request;
  logic [31:0] writeback_offset;
  logic [7:0]  writeback_slot;

  // shadow pool state
  logic [4:0]  free_link [SLOTS];
  logic [4:0]  free_head;
  logic [15:0] use_count [SLOTS];
  logic        slot_dirty [SLOTS];
  logic [31:0] slot_off [SLOTS];
  logic        slot_mapped [SLOTS];

  pool_result_t pending_results[$];
  logic [31:0]  offset_pool [OFFSET_POOL_N];

  int idle_pct;
  int idle_cycles;
  int n_errors;
  int n_items;
  int n_results;
  int n_hits;
  int n_fetches;
  int n_writebacks;
  int n_pool_full;
  int n_bad_slot;

  page_buffer_pool_manager #(.SLOTS(SLOTS)) dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .opcode            (opcode),
    .block_offset      (block_offset),
    .slot_index        (slot_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .result_slot       (result_slot),
    .hit               (hit),
    .fetch_request     (fetch_request),
    .writeback_request (writeback_request),
    .writeback_offset  (writeback_offset),
    .writeback_slot    (writeback_slot)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void pool_clear();
    for (int s = 0; s < SLOTS; s++) begin
      free_link[s]   = 5'(s + 1);
      use_count[s]   = '0;
      slot_dirty[s]  = 1'b0;
      slot_off[s]    = '0;
      slot_mapped[s] = 1'b0;
    end
    free_head = '0;
  endfunction

  // Applies one request to the shadow pool and returns the result it causes.
  function automatic pool_result_t pool_predict(input logic [2:0] op,
                                                input logic [31:0] off,
                                                input logic [7:0] idx);
    pool_result_t r;
    logic [15:0]  dec;
    bit           found;
    int           s;
    r = '0;
    found = 1'b0;
    case (op)
      OP_LOAD: begin
        for (s = 0; s < SLOTS; s++) begin
          if (!found && slot_mapped[s] && slot_off[s] == off) begin
            found = 1'b1;
            r.slot = 8'(s);
            r.hit = 1'b1;
          end
        end
        if (!found) begin
          if (free_head >= SLOTS) begin
            r.status = STAT_NO_FREE;
          end else begin
            s = free_head;
            free_head = free_link[s];
            slot_off[s] = off;
            slot_mapped[s] = 1'b1;
            r.slot = 8'(s);
            r.fetch = 1'b1;
          end
        end
      end
      OP_OBTAIN, OP_RELEASE, OP_MARK_DIRTY, OP_QUERY: begin
        if (idx >= SLOTS) begin
          r.status = STAT_BAD_SLOT;
        end else begin
          case (op)
            OP_OBTAIN: begin
              if (use_count[idx] != COUNT_MAX) use_count[idx] = use_count[idx] + 16'd1;
              r.slot = idx;
            end
            OP_RELEASE: begin
              dec = use_count[idx] - 16'd1;
              if (dec != 0 && !dec[15]) begin
                use_count[idx] = dec;
              end else begin
                use_count[idx] = '0;
                if (!slot_mapped[idx]) begin
                  // already on the free list: just clear, no second push
                  slot_dirty[idx] = 1'b0;
                end else begin
                  if (slot_dirty[idx]) begin
                    r.wb_req = 1'b1;
                    r.wb_off = slot_off[idx];
                    r.wb_slot = idx;
                  end
                  slot_dirty[idx] = 1'b0;
                  slot_mapped[idx] = 1'b0;
                  slot_off[idx] = '0;
                  free_link[idx] = free_head;
                  free_head = idx[4:0];
                end
              end
            end
            OP_MARK_DIRTY: slot_dirty[idx] = 1'b1;
            default: r.wb_off = slot_off[idx];
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // One request beat; the expected result is queued at accept.
  task automatic send_req(input logic [2:0] op, input logic [31:0] off,
                          input logic [7:0] idx);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    block_offset = off;
    slot_index = idx;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(pool_predict(op, off, idx));
    n_items++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < idle_pct);
  end

  always @(posedge clk) begin
    pool_result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (hit) n_hits++;
      if (fetch_request) n_fetches++;
      if (writeback_request) n_writebacks++;
      if (status == STAT_NO_FREE) n_pool_full++;
      if (status == STAT_BAD_SLOT) n_bad_slot++;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected, status %0d slot %0d",
                   $time, status, result_slot);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("result_slot", 32'(want.slot), 32'(result_slot));
        check_field("hit", 32'(want.hit), 32'(hit));
        check_field("fetch_request", 32'(want.fetch), 32'(fetch_request));
        check_field("writeback_request", 32'(want.wb_req), 32'(writeback_request));
        check_field("writeback_offset", want.wb_off, writeback_offset);
        check_field("writeback_slot", 32'(want.wb_slot), 32'(writeback_slot));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles, %0d results pending",
               $time, idle_cycles, pending_results.size());
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_reset_state();
    send_req(OP_QUERY, 32'h0, 8'd0);
    send_req(OP_QUERY, 32'h0, 8'(SLOTS - 1));
    // release of a never-loaded slot clears its dirty mark only
    send_req(OP_MARK_DIRTY, 32'h0, 8'd3);
    send_req(OP_RELEASE, 32'h0, 8'd3);
    send_req(OP_QUERY, 32'h0, 8'd3);
  endtask

  task automatic test_basic_ops();
    send_req(OP_LOAD, 32'h0000_0000, 8'd0);
    send_req(OP_LOAD, 32'h0000_0000, 8'd9);
    send_req(OP_LOAD, 32'hFFFF_FFFF, 8'hFF);
    send_req(OP_OBTAIN, 32'h0, 8'd0);
    send_req(OP_MARK_DIRTY, 32'h0, 8'd0);
    send_req(OP_QUERY, 32'h0, 8'd1);
    send_req(OP_RELEASE, 32'h0, 8'd0);
    send_req(OP_LOAD, 32'hFFFF_FFFF, 8'd0);
    send_req(OP_OBTAIN, 32'h0, 8'd16);
    send_req(OP_RELEASE, 32'h0, 8'hFF);
    send_req(OP_MARK_DIRTY, 32'h0, 8'h80);
    send_req(OP_QUERY, 32'h0, 8'd16);
    for (logic [3:0] k = 4'(OP_FIRST_SPARE); k <= 4'(OP_LAST_SPARE); k++)
      send_req(k[2:0], $urandom, 8'($urandom));
  endtask

  task automatic test_pool_exhausted();
    for (int k = 0; k < SLOTS; k++)
      send_req(OP_LOAD, 32'h0001_0000 * (k + 1), 8'($urandom));
    // pool is full now; freeing slot 1 must make its slot the next one popped
    send_req(OP_LOAD, 32'h00AB_CDEF, 8'd0);
    send_req(OP_RELEASE, 32'h0, 8'd1);
    send_req(OP_LOAD, 32'h00AB_CDEF, 8'd0);
  endtask

  task automatic test_random_mix();
    int          roll;
    logic [2:0]  op;
    logic [31:0] off;
    logic [7:0]  idx;
    for (int k = 0; k < OFFSET_POOL_N; k++) offset_pool[k] = $urandom;
    offset_pool[0] = 32'h0;
    offset_pool[1] = 32'hFFFF_FFFF;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n >= 800 && n < 1100) ? 0 : 11;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) idx = 8'($urandom_range(SLOTS, 255));
      else idx = 8'($urandom_range(0, SLOTS - 1));
      if ($urandom_range(0, 3) == 0) off = $urandom;
      else off = offset_pool[$urandom_range(0, OFFSET_POOL_N - 1)];
      if (roll < 35) op = OP_LOAD;
      else if (roll < 55) op = OP_OBTAIN;
      else if (roll < 80) op = OP_RELEASE;
      else if (roll < 90) op = OP_MARK_DIRTY;
      else if (roll < 96) op = OP_QUERY;
      else op = 3'($urandom_range(int'(OP_FIRST_SPARE), int'(OP_LAST_SPARE)));
      send_req(op, off, idx);
    end
    idle_pct = 11;
  endtask

  // count climbs, then drops back through zero with one release too many
  task automatic test_count_balance();
    logic [7:0] idx;
    idx = 8'($urandom_range(0, SLOTS - 1));
    send_req(OP_LOAD, 32'h5A5A_0000, 8'd0);
    for (int k = 0; k < 6; k++)
      send_req(OP_OBTAIN, $urandom, idx);
    send_req(OP_MARK_DIRTY, 32'h0, idx);
    for (int k = 0; k < 7; k++)
      send_req(OP_RELEASE, 32'h0, idx);
    send_req(OP_OBTAIN, 32'h0, idx);
    send_req(OP_QUERY, 32'h0, idx);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    block_offset = '0;
    slot_index = '0;
    out_stall = 1'b0;
    idle_pct = 11;
    idle_cycles = 0;
    n_errors = 0;
    n_items = 0;
    n_results = 0;
    n_hits = 0;
    n_fetches = 0;
    n_writebacks = 0;
    n_pool_full = 0;
    n_bad_slot = 0;
    pool_clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_basic_ops();
    test_pool_exhausted();
    test_random_mix();
    test_count_balance();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests: %0d hits, %0d fetches, %0d writebacks,", n_items,
             n_hits, n_fetches, n_writebacks);
    $display("  %0d pool-full, %0d bad-index; %0d results checked, %0d mismatches",
             n_pool_full, n_bad_slot, n_results, n_errors);
    if (n_errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
